// File: rtl/rotate_add_random_generator_defines.svh
// Assertion macros for the rotate-add random generator.
// Each check is sampled on the rising edge of aclk and is switched off during reset.
`ifndef ROTATE_ADD_RANDOM_GENERATOR_DEFINES_SVH
`define ROTATE_ADD_RANDOM_GENERATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent holds in the same cycle as the antecedent.
`define RAG_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("rotate_add_random_generator: check failed");

// The consequent holds in the cycle after the antecedent.
`define RAG_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("rotate_add_random_generator: check failed");

`else

`define RAG_ASSERT_NOW(label, cond, prop)
`define RAG_ASSERT_NEXT(label, cond, prop)

`endif

`endif

// File: rtl/rag_pkg.sv
package rag_pkg;

    // Request kinds carried in the input tuser field.
    localparam logic [1:0] REQ_RAW    = 2'd0;
    localparam logic [1:0] REQ_DOUBLE = 2'd1;
    localparam logic [1:0] REQ_RESEED = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ROT_FIRST  = 2'd0;
    localparam logic [1:0] CFG_ROT_SECOND = 2'd1;
    localparam logic [1:0] CFG_ROT_THIRD  = 2'd2;
    localparam logic [1:0] CFG_BASE_OFS   = 2'd3;

    // Register reset values, also restored by a reseed.
    localparam logic [5:0]  ROT_FIRST_RST  = 6'd13;
    localparam logic [5:0]  ROT_SECOND_RST = 6'd3;
    localparam logic [5:0]  ROT_THIRD_RST  = 6'd23;
    localparam logic [15:0] BASE_OFS_RST   = 16'd0;

    // Double conversion constants.
    localparam logic [63:0] DBL_SMALL_LIMIT = 64'hfff;
    localparam logic [10:0] DBL_EXP_BASE    = 11'd1022;
    localparam logic [6:0]  DBL_ALIGN       = 7'd11;

    typedef struct packed {
        logic [63:0] word_a;
        logic [63:0] word_b;
        logic [63:0] word_c;
    } rag_state_t;

    typedef struct packed {
        logic [5:0]  rot_first;
        logic [5:0]  rot_second;
        logic [5:0]  rot_third;
        logic [15:0] base_ofs;
    } rag_cfg_t;

    localparam rag_cfg_t CFG_RST = '{
        rot_first:  ROT_FIRST_RST,
        rot_second: ROT_SECOND_RST,
        rot_third:  ROT_THIRD_RST,
        base_ofs:   BASE_OFS_RST
    };

    // State left by a reseed with the given seed.
    function automatic rag_state_t reseed_state(input logic [63:0] seed);
        rag_state_t s;
        s.word_a = 64'd0;
        s.word_b = 64'd1;
        s.word_c = seed ^ 64'd1;
        return s;
    endfunction

    // Left rotation; an amount of zero leaves the word as it is.
    function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] r);
        return (x << r) | (x >> (7'd64 - {1'b0, r}));
    endfunction

endpackage

// File: rtl/rag_draw.sv
module rag_draw
    import rag_pkg::*;
(
    input  rag_state_t  state_i,
    input  rag_cfg_t    cfg_i,
    output logic [63:0] value_o,
    output rag_state_t  state_o,
    output rag_cfg_t    cfg_o
);

    rag_state_t eff_state;
    rag_cfg_t   eff_cfg;
    logic [63:0] new_a;

    // An all-zero state is first reseeded with seed zero, registers included.
    always_comb begin
        if (state_i.word_a == 64'd0 && state_i.word_b == 64'd0 &&
            state_i.word_c == 64'd0) begin
            eff_state = reseed_state(64'd0);
            eff_cfg   = CFG_RST;
        end else begin
            eff_state = state_i;
            eff_cfg   = cfg_i;
        end
    end

    // The draw is taken before the words advance.
    assign value_o = (eff_state.word_a ^ eff_state.word_b ^ eff_state.word_c) +
                     {48'd0, eff_cfg.base_ofs};

    // Rotate-add update; the third word uses the fresh first word.
    assign new_a          = rotl64(eff_state.word_a, eff_cfg.rot_first) + eff_state.word_b;
    assign state_o.word_a = new_a;
    assign state_o.word_b = rotl64(eff_state.word_b, eff_cfg.rot_second) + eff_state.word_c;
    assign state_o.word_c = rotl64(eff_state.word_c, eff_cfg.rot_third) + new_a;
    assign cfg_o          = eff_cfg;

endmodule

// File: rtl/rag_dbl.sv
module rag_dbl
    import rag_pkg::*;
(
    input  logic [63:0] draw_i,
    input  logic [63:0] extra_i,
    output logic [63:0] value_o,
    output logic        need_second_o
);

    logic [6:0]   lead_zeros;
    logic [63:0]  mant;
    logic [127:0] joined;
    logic [10:0]  expo;
    logic         below_limit;

    // Leading-zero count: the highest set bit wins.
    always_comb begin
        lead_zeros = 7'd64;
        for (int i = 0; i < 64; i++) begin
            if (draw_i[i]) begin
                lead_zeros = 7'(63 - i);
            end
        end
    end

    assign below_limit = draw_i < DBL_SMALL_LIMIT;

    // Clear the leading one, then align the draw with the second draw beneath it.
    assign mant   = draw_i & ~(64'd1 << (7'd63 - lead_zeros));
    assign joined = {mant, extra_i} << lead_zeros;
    assign expo   = DBL_EXP_BASE - {4'd0, lead_zeros};

    assign need_second_o = !below_limit && (lead_zeros > DBL_ALIGN);
    assign value_o       = below_limit ? 64'd0 : {1'b0, expo, joined[126:75]};

endmodule

// File: rtl/rotate_add_random_generator.sv
// Rotate-add random generator.
// Input channel s_*: one request per transfer; tuser carries the request kind
// (raw draw, double in [0,1) or reseed) and tdata the seed used by a reseed.
// Output channel m_*: one 64-bit result per raw or double request; a reseed or
// an unused request kind gives no result.
// Configuration: cfg_wr_en, cfg_index and cfg_wdata write the three rotation
// amounts and the base offset; write only while no request is in flight.
// Each request is first registered in the input register, then its result is
// registered in the output register.
// Throughput: one request per cycle while the receiver does not stall; the state
// words are updated once per request, including the second draw that some double
// requests need.
// Reset returns the state words to 0, 1, 1 and the registers to their reset
// values. When the receiver stalls, the result is held in the output register,
// one further request waits in the input register and s_tready then falls.
`include "rotate_add_random_generator_defines.svh"

module rotate_add_random_generator
    import rag_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [63:0] seed_value
    input  logic [1:0]  s_tuser,    // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [63:0] random_value
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic        in_valid_reg, in_valid_next;
    logic [1:0]  req_reg;
    logic [63:0] seed_reg;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_data_reg;

    rag_state_t  state_reg, state_next;
    rag_cfg_t    cfg_reg, cfg_next;

    rag_state_t  state_one, state_two;
    rag_cfg_t    cfg_one, cfg_two;
    logic [63:0] draw_one, draw_two, dbl_value;
    logic        need_second;
    logic        gives_result, advance;

    // Two draws in a row; the second starts from what the first leaves.
    rag_draw u_draw_one (
        .state_i (state_reg),
        .cfg_i   (cfg_reg),
        .value_o (draw_one),
        .state_o (state_one),
        .cfg_o   (cfg_one)
    );

    rag_draw u_draw_two (
        .state_i (state_one),
        .cfg_i   (cfg_one),
        .value_o (draw_two),
        .state_o (state_two),
        .cfg_o   (cfg_two)
    );

    rag_dbl u_dbl (
        .draw_i        (draw_one),
        .extra_i       (draw_two),
        .value_o       (dbl_value),
        .need_second_o (need_second)
    );

    // A held request moves on when it gives no result or its result has somewhere to go.
    assign gives_result = (req_reg == REQ_RAW) || (req_reg == REQ_DOUBLE);
    assign advance      = in_valid_reg && (!gives_result || !out_valid_reg || m_tready);
    assign s_tready     = !in_valid_reg || advance;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;

    // Input register and output valid flag.
    always_comb begin
        in_valid_next = in_valid_reg;
        if (advance) begin
            in_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (advance && gives_result) begin
            out_valid_next = 1'b1;
        end
    end

    // State and register update for the request being processed.
    always_comb begin
        state_next = state_reg;
        cfg_next   = cfg_reg;
        if (advance) begin
            case (req_reg)
                REQ_RAW: begin
                    state_next = state_one;
                    cfg_next   = cfg_one;
                end
                REQ_DOUBLE: begin
                    state_next = need_second ? state_two : state_one;
                    cfg_next   = need_second ? cfg_two : cfg_one;
                end
                REQ_RESEED: begin
                    state_next = reseed_state(seed_reg);
                    cfg_next   = CFG_RST;
                end
                default: begin
                    state_next = state_reg;
                end
            endcase
        end
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ROT_FIRST:  cfg_next.rot_first  = cfg_wdata[5:0];
                CFG_ROT_SECOND: cfg_next.rot_second = cfg_wdata[5:0];
                CFG_ROT_THIRD:  cfg_next.rot_third  = cfg_wdata[5:0];
                CFG_BASE_OFS:   cfg_next.base_ofs   = cfg_wdata;
                default:        cfg_next            = cfg_next;
            endcase
        end
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{word_a: 64'd0, word_b: 64'd1, word_c: 64'd1};
            cfg_reg       <= CFG_RST;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
            cfg_reg       <= cfg_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg  <= s_tuser;
            seed_reg <= s_tdata;
        end
        if (advance && gives_result) begin
            out_data_reg <= (req_reg == REQ_DOUBLE) ? dbl_value : draw_one;
        end
    end

    // A request that cannot move on stays in the input register.
    `RAG_ASSERT_NEXT(a_in_held, in_valid_reg && !advance, in_valid_reg)

    // A reseed leaves the first two words at zero and one.
    `RAG_ASSERT_NEXT(a_reseed_words, advance && req_reg == REQ_RESEED && !cfg_wr_en,
        state_reg.word_a == 64'd0 && state_reg.word_b == 64'd1)

    // A result is only loaded when the output register is free or being emptied.
    `RAG_ASSERT_NOW(a_out_free, advance && gives_result, !out_valid_reg || m_tready)

    // A rotation write lands in its register.
    `RAG_ASSERT_NEXT(a_cfg_write, cfg_wr_en && cfg_index == CFG_ROT_FIRST && !advance,
        cfg_reg.rot_first == $past(cfg_wdata[5:0]))

endmodule
